/* src/rfs_pkg.sv */
// Shared types, codes and lookup tables for the rgb fade sequencer.
// No dependencies; imported by rgb_fade_sequencer_with_serial_control.
`timescale 1ns / 1ps

package rfs_pkg;

   // duty levels, 0 is fully lit
   localparam logic [7:0] DUTY_ON  = 8'h00;
   localparam logic [7:0] DUTY_OFF = 8'hFF;

   // channel slots inside a duty set
   localparam logic [1:0] CHAN_BLUE  = 2'd0;
   localparam logic [1:0] CHAN_RED   = 2'd1;
   localparam logic [1:0] CHAN_GREEN = 2'd2;

   // request kinds
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_BYTE = 1'b1;

   // reply codes
   localparam logic [2:0] REPLY_NONE   = 3'd0;
   localparam logic [2:0] REPLY_STATUS = 3'd1;
   localparam logic [2:0] REPLY_AUTO   = 3'd2;
   localparam logic [2:0] REPLY_RESET  = 3'd3;
   localparam logic [2:0] REPLY_ERROR  = 3'd4;

   // command bytes in the last frame slot
   localparam logic [7:0] CMD_STATUS = 8'h00;
   localparam logic [7:0] CMD_AUTO   = 8'h01;
   localparam logic [7:0] CMD_RESET  = 8'h02;
   localparam logic [7:0] GROUP_BYTE_MAX = 8'h0E;

   // frame slots
   localparam logic [2:0] FRAME_BLUE    = 3'd0;
   localparam logic [2:0] FRAME_RED     = 3'd1;
   localparam logic [2:0] FRAME_GREEN   = 3'd2;
   localparam logic [2:0] FRAME_GROUPS  = 3'd3;
   localparam logic [2:0] FRAME_COMMAND = 3'd4;

   // configuration register indexes and reset values
   localparam logic CSR_PATTERN_LEN = 1'b0;
   localparam logic CSR_OVERLAP     = 1'b1;
   localparam logic [10:0] PATTERN_LEN_RESET = 11'd1200;
   localparam logic [7:0]  OVERLAP_RESET     = 8'd200;

   // ramp speeds
   localparam logic [3:0] SPEED_1  = 4'd1;
   localparam logic [3:0] SPEED_3  = 4'd3;
   localparam logic [3:0] SPEED_5  = 4'd5;
   localparam logic [3:0] SPEED_15 = 4'd15;

   typedef logic [2:0][7:0] duty_set_type;

   // one result beat
   typedef struct packed {
      logic         auto_active;
      logic         reset_request;
      logic [2:0]   reply_code;
      logic [2:0]   groups;
      duty_set_type duty;
   } rsp_fields_type;

   // colour sequence, steps 1 to 15 (step 0 is the overlap step)
   localparam logic [1:0] SEQ_CHAN [16] = '{2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 2'd0, 2'd2, 2'd1,
                                           2'd0, 2'd1, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
   localparam logic [7:0] SEQ_VAL [16] = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
                                          8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
                                          8'h00, 8'hFF};

   // move a duty toward its target, stopping on it
   function automatic logic [7:0] ramp_duty(input logic [7:0] cur, input logic [7:0] tgt,
                                            input logic [3:0] speed);
      logic [7:0] diff;
      logic [7:0] res;
      res = cur;
      if (tgt < cur) begin
         diff = cur - tgt;
         res  = (diff < {4'd0, speed}) ? tgt : cur - {4'd0, speed};
      end else if (tgt > cur) begin
         diff = tgt - cur;
         res  = (diff < {4'd0, speed}) ? tgt : cur + {4'd0, speed};
      end
      return res;
   endfunction

   // group pattern at a counter value: bit 3 set when the pattern applies
   function automatic logic [3:0] pattern_groups(input logic [10:0] p);
      logic [3:0] g;
      case (p)
         11'd3:   g = 4'b1_110;
         11'd6:   g = 4'b1_101;
         11'd9:   g = 4'b1_011;
         11'd12:  g = 4'b1_111;
         11'd300: g = 4'b1_001;
         11'd301: g = 4'b1_010;
         11'd302: g = 4'b1_100;
         11'd303: g = 4'b1_001;
         11'd304: g = 4'b1_010;
         11'd305: g = 4'b1_100;
         11'd306: g = 4'b1_001;
         11'd307: g = 4'b1_010;
         11'd308: g = 4'b1_100;
         11'd309: g = 4'b1_111;
         11'd600: g = 4'b1_110;
         11'd605: g = 4'b1_100;
         11'd610: g = 4'b1_000;
         11'd615: g = 4'b1_001;
         11'd620: g = 4'b1_011;
         11'd625: g = 4'b1_111;
         default: g = 4'b0_000;
      endcase
      // blink window
      if (p >= 11'd900 && p <= 11'd911) begin
         g = p[0] ? 4'b1_111 : 4'b1_000;
      end
      return g;
   endfunction

endpackage

/* src/rgb_fade_sequencer_with_serial_control.sv */
// Top level of the rgb fade sequencer: state update, config registers, result buffer.
// Depends on rfs_pkg.
`timescale 1ns / 1ps

// Three-channel LED fade controller driven by a request stream.
// Request beats are either timer ticks (req_tuser[0] = 0) or received serial
// bytes (req_tuser[0] = 1, byte in req_tdata, error flag in req_tuser[1]).
// Every accepted request yields exactly one response beat carrying the three
// duties, the group enables, a reply code, a reset flag and the auto flag,
// all as they stand after the request.
// The whole update is one pass of logic from the state registers, so a
// request is taken every cycle while req_tready is high, and its response
// is registered into a two-entry response buffer, which lets requests
// keep flowing while a response waits: req_tready drops only when both
// entries are full, i.e. after two beats stall on rsp_tready.
// Configuration (pattern length, overlap threshold) is written through csr_we /
// csr_addr / csr_wdata by the user only while no request is in flight (not enforced).
// Synchronous reset returns all state to auto mode, duties off, speed 1,
// and the registers to 1200 and 200; the reset command byte restores the
// same state but keeps the register values.
module rgb_fade_sequencer_with_serial_control (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [0] kind, [1] rx_error
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] blue_duty, [15:8] red_duty, [23:16] green_duty, [24] group_one_on,
   // [25] group_two_on, [26] group_three_on, [29:27] reply_code,
   // [30] reset_request, [31] auto_active
   output logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [10:0] csr_wdata
);
   import rfs_pkg::*;

   // configuration
   logic [10:0] pattern_len_ff;
   logic [7:0]  overlap_ff;

   // block state
   logic [2:0]   frame_pos_ff, frame_pos_in;
   logic         auto_mode_ff, auto_mode_in;
   duty_set_type cur_duty_ff, cur_duty_in;
   duty_set_type tgt_duty_ff, tgt_duty_in;
   logic [4:0]   seq_step_ff, seq_step_in;
   logic [3:0]   speed_ff, speed_in;
   logic         parity_ff, parity_in;
   logic [10:0]  pattern_ff, pattern_in;
   logic [2:0]   groups_ff, groups_in;

   logic [2:0]   reply;
   logic         reset_req;
   logic [1:0]   seq_chan;
   logic [7:0]   seq_val;
   logic [10:0]  pattern_inc;
   logic [3:0]   pattern_hit;
   rsp_fields_type result;

   // response buffer
   rsp_fields_type head_ff, tail_ff;
   logic           head_valid_ff, tail_valid_ff;
   logic           req_acc, rsp_acc;

   assign req_tready = ~tail_valid_ff;
   assign req_acc    = req_tvalid & req_tready;
   assign rsp_tvalid = head_valid_ff;
   assign rsp_acc    = head_valid_ff & rsp_tready;
   assign rsp_tdata  = head_ff;

   assign seq_chan    = SEQ_CHAN[seq_step_ff[3:0]];
   assign seq_val     = SEQ_VAL[seq_step_ff[3:0]];
   assign pattern_inc = pattern_ff + 11'd1;
   assign pattern_hit = pattern_groups(pattern_inc);

   // next state for one request
   always_comb begin
      frame_pos_in = frame_pos_ff;
      auto_mode_in = auto_mode_ff;
      cur_duty_in  = cur_duty_ff;
      tgt_duty_in  = tgt_duty_ff;
      seq_step_in  = seq_step_ff;
      speed_in     = speed_ff;
      parity_in    = parity_ff;
      pattern_in   = pattern_ff;
      groups_in    = groups_ff;
      reply        = REPLY_NONE;
      reset_req    = 1'b0;
      if (req_tuser[0] == KIND_TICK) begin
         if (auto_mode_ff) begin
            if (!parity_ff) begin
               // colour sequence
               if (seq_step_ff == 5'd0) begin
                  tgt_duty_in[CHAN_RED] = DUTY_ON;
                  if (cur_duty_ff[CHAN_RED] <= overlap_ff &&
                      tgt_duty_ff[CHAN_BLUE] == DUTY_OFF) begin
                     tgt_duty_in[CHAN_BLUE] = DUTY_ON;
                  end
                  if (cur_duty_ff[CHAN_BLUE] <= overlap_ff &&
                      tgt_duty_ff[CHAN_GREEN] == DUTY_OFF) begin
                     tgt_duty_in[CHAN_GREEN] = DUTY_ON;
                  end
                  if (cur_duty_ff[CHAN_GREEN] == DUTY_ON) begin
                     seq_step_in = 5'd1;
                  end
               end else if (!seq_step_ff[4]) begin
                  tgt_duty_in[seq_chan] = seq_val;
                  if (cur_duty_ff[seq_chan] == seq_val) begin
                     seq_step_in = seq_step_ff + 5'd1;
                  end
               end else begin
                  seq_step_in = 5'd0;
                  case (speed_ff)
                     SPEED_1: speed_in = SPEED_3;
                     SPEED_3: speed_in = SPEED_5;
                     SPEED_5: speed_in = SPEED_15;
                     default: speed_in = SPEED_1;
                  endcase
               end
               // group pattern counter
               if (pattern_hit[3]) begin
                  groups_in = pattern_hit[2:0];
               end
               pattern_in = (pattern_inc == pattern_len_ff) ? 11'd0 : pattern_inc;
            end
            parity_in = ~parity_ff;
            // ramp every channel toward its new target
            for (int i = 0; i < 3; i++) begin
               cur_duty_in[i] = ramp_duty(cur_duty_ff[i], tgt_duty_in[i], speed_in);
            end
         end
      end else begin
         auto_mode_in = 1'b0;
         if (!req_tuser[1]) begin
            case (frame_pos_ff)
               FRAME_BLUE, FRAME_RED, FRAME_GREEN: begin
                  cur_duty_in[frame_pos_ff[1:0]] = req_tdata;
                  frame_pos_in = frame_pos_ff + 3'd1;
               end
               FRAME_GROUPS: begin
                  groups_in = req_tdata[3:1];
                  if (req_tdata > GROUP_BYTE_MAX) begin
                     reply = REPLY_ERROR;
                  end
                  frame_pos_in = FRAME_COMMAND;
               end
               FRAME_COMMAND: begin
                  frame_pos_in = FRAME_BLUE;
                  case (req_tdata)
                     CMD_STATUS: reply = REPLY_STATUS;
                     CMD_AUTO: begin
                        reply        = REPLY_AUTO;
                        auto_mode_in = 1'b1;
                     end
                     CMD_RESET: begin
                        reply        = REPLY_RESET;
                        reset_req    = 1'b1;
                        auto_mode_in = 1'b1;
                        cur_duty_in  = {3{DUTY_OFF}};
                        tgt_duty_in  = {3{DUTY_OFF}};
                        seq_step_in  = 5'd0;
                        speed_in     = SPEED_1;
                        parity_in    = 1'b0;
                        pattern_in   = 11'd0;
                        groups_in    = 3'd0;
                     end
                     default: reply = REPLY_ERROR;
                  endcase
               end
               default: ;
            endcase
         end
      end
      result.auto_active   = auto_mode_in;
      result.reset_request = reset_req;
      result.reply_code    = reply;
      result.groups        = groups_in;
      result.duty          = cur_duty_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pos_ff <= FRAME_BLUE;
         auto_mode_ff <= 1'b1;
         cur_duty_ff  <= {3{DUTY_OFF}};
         tgt_duty_ff  <= {3{DUTY_OFF}};
         seq_step_ff  <= 5'd0;
         speed_ff     <= SPEED_1;
         parity_ff    <= 1'b0;
         pattern_ff   <= 11'd0;
         groups_ff    <= 3'd0;
      end else if (req_acc) begin
         frame_pos_ff <= frame_pos_in;
         auto_mode_ff <= auto_mode_in;
         cur_duty_ff  <= cur_duty_in;
         tgt_duty_ff  <= tgt_duty_in;
         seq_step_ff  <= seq_step_in;
         speed_ff     <= speed_in;
         parity_ff    <= parity_in;
         pattern_ff   <= pattern_in;
         groups_ff    <= groups_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_len_ff <= PATTERN_LEN_RESET;
         overlap_ff     <= OVERLAP_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PATTERN_LEN: pattern_len_ff <= csr_wdata;
            CSR_OVERLAP:     overlap_ff     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // response buffer occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else if (rsp_acc) begin
         if (tail_valid_ff) begin
            tail_valid_ff <= req_acc;
         end else begin
            head_valid_ff <= req_acc;
         end
      end else if (req_acc) begin
         if (!head_valid_ff) begin
            head_valid_ff <= 1'b1;
         end else begin
            tail_valid_ff <= 1'b1;
         end
      end
   end

   // response buffer payload
   always_ff @(posedge clock) begin
      if (rsp_acc) begin
         if (tail_valid_ff) begin
            head_ff <= tail_ff;
            if (req_acc) begin
               tail_ff <= result;
            end
         end else if (req_acc) begin
            head_ff <= result;
         end
      end else if (req_acc) begin
         if (!head_valid_ff) begin
            head_ff <= result;
         end else begin
            tail_ff <= result;
         end
      end
   end

`ifndef NO_ASSERTIONS
   // second buffer entry only fills behind the first
   a_tail_behind_head: assert property (@(posedge clock) disable iff (reset)
      tail_valid_ff |-> head_valid_ff)
      else $error("response buffer tail valid without head");

   // a byte with a receive error does not move the frame
   a_err_byte_holds_frame: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser[0] == KIND_BYTE && req_tuser[1]) |=> $stable(frame_pos_ff))
      else $error("errored byte changed frame position");

   // ticks in manual mode leave the duties alone
   a_manual_tick_holds: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser[0] == KIND_TICK && !auto_mode_ff) |=>
         ($stable(cur_duty_ff) && $stable(tgt_duty_ff)))
      else $error("tick in manual mode changed duties");

   // any received byte leaves the block in manual mode unless auto is commanded
   a_byte_leaves_auto: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser[0] == KIND_BYTE && frame_pos_ff != FRAME_COMMAND) |=>
         !auto_mode_ff)
      else $error("byte outside command slot kept auto mode");
`endif

endmodule

/* verif/rgb_fade_sequencer_with_serial_control_tb.sv */
// Self-checking bench for rgb_fade_sequencer_with_serial_control: a directed opening table,
// then random tick bursts, serial frames and noise, each beat checked against a fader
// predictor or a fixed table value. Depends on rfs_pkg and the top level under src.
`timescale 1ns / 1ps

module rgb_fade_sequencer_with_serial_control_tb;
   import rfs_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 80;
   localparam int PHASE_ITEMS   = 280;
   localparam int IDLE_PERCENT  = 17;

   // colour sequence, slot 0 unused (overlap step)
   localparam logic [1:0] STEP_CHAN [16] = '{2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 2'd0, 2'd2, 2'd1,
                                             2'd0, 2'd1, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
   localparam logic [7:0] STEP_LEVEL [16] = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00,
                                              8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF,
                                              8'h00, 8'hFF, 8'h00, 8'hFF};

   // one row of the opening table
   typedef struct packed {
      logic           kind;
      logic [7:0]     data;
      logic           err;
      logic           hand_checked;
      rsp_fields_type want;
   } opening_row_type;

   localparam opening_row_type OPENING_ROWS [25] = '{
      {KIND_TICK, 8'h00, 1'b0, 1'b0, 32'h0},
      {KIND_TICK, 8'h00, 1'b0, 1'b0, 32'h0},
      {KIND_BYTE, 8'hAA, 1'b1, 1'b0, 32'h0},
      {KIND_TICK, 8'h00, 1'b0, 1'b0, 32'h0},
      {KIND_BYTE, 8'h00, 1'b0, 1'b0, 32'h0},
      {KIND_BYTE, 8'hFF, 1'b0, 1'b0, 32'h0},
      {KIND_BYTE, 8'h80, 1'b0, 1'b0, 32'h0},
      // group byte above the limit: groups still taken, error reply
      {KIND_BYTE, 8'h0F, 1'b0, 1'b1,
       {1'b0, 1'b0, REPLY_ERROR, 3'b111, 8'h80, 8'hFF, 8'h00}},
      {KIND_BYTE, CMD_STATUS, 1'b0, 1'b0, 32'h0},
      {KIND_BYTE, 8'h01, 1'b0, 1'b0, 32'h0},
      {KIND_BYTE, 8'h02, 1'b0, 1'b0, 32'h0},
      {KIND_BYTE, 8'h03, 1'b0, 1'b0, 32'h0},
      {KIND_BYTE, GROUP_BYTE_MAX, 1'b0, 1'b0, 32'h0},
      // unknown command byte
      {KIND_BYTE, 8'h05, 1'b0, 1'b1,
       {1'b0, 1'b0, REPLY_ERROR, 3'b111, 8'h03, 8'h02, 8'h01}},
      {KIND_BYTE, 8'h55, 1'b0, 1'b0, 32'h0},
      {KIND_BYTE, 8'h99, 1'b1, 1'b0, 32'h0},
      {KIND_BYTE, 8'h66, 1'b0, 1'b0, 32'h0},
      {KIND_BYTE, 8'h77, 1'b0, 1'b0, 32'h0},
      {KIND_BYTE, 8'h00, 1'b0, 1'b0, 32'h0},
      {KIND_BYTE, CMD_AUTO, 1'b0, 1'b0, 32'h0},
      {KIND_BYTE, 8'hFF, 1'b0, 1'b0, 32'h0},
      {KIND_BYTE, 8'hFF, 1'b0, 1'b0, 32'h0},
      {KIND_BYTE, 8'hFF, 1'b0, 1'b0, 32'h0},
      {KIND_BYTE, 8'hFF, 1'b0, 1'b0, 32'h0},
      // reset command: back to the state after reset
      {KIND_BYTE, CMD_RESET, 1'b0, 1'b1,
       {1'b1, 1'b1, REPLY_RESET, 3'b000, 8'hFF, 8'hFF, 8'hFF}}
   };

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] data_byte
   logic [1:0]  req_tuser  = 2'b00;   // [0] kind, [1] rx_error
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [23:0] blue/red/green duty, [26:24] groups, [29:27] reply_code,
   // [30] reset_request, [31] auto_active
   logic [31:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic        csr_addr   = CSR_PATTERN_LEN;
   logic [10:0] csr_wdata  = 11'd0;

   // fader predictor state and its copy of the registers
   logic [2:0]  fr_pos;
   logic        auto_on;
   logic [7:0]  duty_now  [3];
   logic [7:0]  duty_goal [3];
   logic [4:0]  seq_idx;
   logic [3:0]  fade_rate;
   logic        half_tick;
   logic [10:0] pat_count;
   logic [2:0]  groups_now;
   logic [10:0] cfg_pat_len;
   logic [7:0]  cfg_overlap;

   rsp_fields_type pending_status_q [$];
   int  mismatch_count = 0;
   int  status_count   = 0;
   int  sent_items     = 0;
   int  cycle_count    = 0;
   bit  idle_on        = 1'b1;
   bit  hold_rsp       = 1'b0;

   rgb_fade_sequencer_with_serial_control u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------- predictor ----------------

   function automatic void clear_fader_state();
      fr_pos     = FRAME_BLUE;
      auto_on    = 1'b1;
      for (int c = 0; c < 3; c++) begin
         duty_now[c]  = DUTY_OFF;
         duty_goal[c] = DUTY_OFF;
      end
      seq_idx    = 5'd0;
      fade_rate  = SPEED_1;
      half_tick  = 1'b0;
      pat_count  = 11'd0;
      groups_now = 3'b000;
   endfunction

   function automatic logic [7:0] approach(input logic [7:0] cur, input logic [7:0] tgt,
                                           input logic [3:0] rate);
      int gap;
      if (tgt < cur) begin
         gap = int'(cur) - int'(tgt);
         return (gap < int'(rate)) ? tgt : cur - {4'd0, rate};
      end
      if (tgt > cur) begin
         gap = int'(tgt) - int'(cur);
         return (gap < int'(rate)) ? tgt : cur + {4'd0, rate};
      end
      return cur;
   endfunction

   function automatic void step_colour_sequence();
      logic [1:0] ch;
      if (seq_idx == 5'd0) begin
         // overlap step: red on, blue and green follow once the previous reaches overlap
         duty_goal[CHAN_RED] = DUTY_ON;
         if (duty_now[CHAN_RED] <= cfg_overlap && duty_goal[CHAN_BLUE] == DUTY_OFF)
            duty_goal[CHAN_BLUE] = DUTY_ON;
         if (duty_now[CHAN_BLUE] <= cfg_overlap && duty_goal[CHAN_GREEN] == DUTY_OFF)
            duty_goal[CHAN_GREEN] = DUTY_ON;
         if (duty_now[CHAN_GREEN] == DUTY_ON)
            seq_idx = 5'd1;
      end else if (seq_idx < 5'd16) begin
         ch = STEP_CHAN[seq_idx[3:0]];
         duty_goal[ch] = STEP_LEVEL[seq_idx[3:0]];
         if (duty_now[ch] == STEP_LEVEL[seq_idx[3:0]])
            seq_idx = seq_idx + 5'd1;
      end else begin
         // end of a pass: next ramp speed
         seq_idx = 5'd0;
         case (fade_rate)
            SPEED_1: fade_rate = SPEED_3;
            SPEED_3: fade_rate = SPEED_5;
            SPEED_5: fade_rate = SPEED_15;
            default: fade_rate = SPEED_1;
         endcase
      end
   endfunction

   function automatic void step_group_pattern();
      int g;
      g = -1;
      pat_count = pat_count + 11'd1;
      case (pat_count)
         11'd3:   g = 6;
         11'd6:   g = 5;
         11'd9:   g = 3;
         11'd12:  g = 7;
         11'd309: g = 7;
         11'd600: g = 6;
         11'd605: g = 4;
         11'd610: g = 0;
         11'd615: g = 1;
         11'd620: g = 3;
         11'd625: g = 7;
         default: g = -1;
      endcase
      // rotating single group
      if (pat_count >= 11'd300 && pat_count <= 11'd308)
         g = 1 << ((int'(pat_count) - 300) % 3);
      // blink window
      if (pat_count >= 11'd900 && pat_count <= 11'd911)
         g = pat_count[0] ? 7 : 0;
      if (g >= 0)
         groups_now = g[2:0];
      if (pat_count == cfg_pat_len)
         pat_count = 11'd0;
   endfunction

   function automatic rsp_fields_type predict_fader_status(input logic kind,
                                                           input logic [7:0] data,
                                                           input logic err);
      rsp_fields_type r;
      logic [2:0] reply;
      logic       rst;
      reply = REPLY_NONE;
      rst   = 1'b0;
      if (kind == KIND_TICK) begin
         if (auto_on) begin
            if (!half_tick) begin
               step_colour_sequence();
               step_group_pattern();
            end
            half_tick = ~half_tick;
            for (int c = 0; c < 3; c++)
               duty_now[c] = approach(duty_now[c], duty_goal[c], fade_rate);
         end
      end else begin
         auto_on = 1'b0;
         if (!err) begin
            case (fr_pos)
               FRAME_BLUE, FRAME_RED, FRAME_GREEN: begin
                  duty_now[fr_pos[1:0]] = data;
                  fr_pos = fr_pos + 3'd1;
               end
               FRAME_GROUPS: begin
                  groups_now = data[3:1];
                  if (data > GROUP_BYTE_MAX)
                     reply = REPLY_ERROR;
                  fr_pos = FRAME_COMMAND;
               end
               FRAME_COMMAND: begin
                  fr_pos = FRAME_BLUE;
                  case (data)
                     CMD_STATUS: reply = REPLY_STATUS;
                     CMD_AUTO: begin
                        reply   = REPLY_AUTO;
                        auto_on = 1'b1;
                     end
                     CMD_RESET: begin
                        reply = REPLY_RESET;
                        rst   = 1'b1;
                        clear_fader_state();
                     end
                     default: reply = REPLY_ERROR;
                  endcase
               end
               default: ;
            endcase
         end
      end
      r.duty[CHAN_BLUE]  = duty_now[CHAN_BLUE];
      r.duty[CHAN_RED]   = duty_now[CHAN_RED];
      r.duty[CHAN_GREEN] = duty_now[CHAN_GREEN];
      r.groups           = groups_now;
      r.reply_code       = reply;
      r.reset_request    = rst;
      r.auto_active      = auto_on;
      return r;
   endfunction

   // ---------------- reporting and checking ----------------

   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("status beat %0d %s: got %0d, expected %0d",
                                   status_count, name, got, want));
   endtask

   // result beats against the oldest expectation
   always @(posedge clock) begin : rsp_check
      rsp_fields_type seen;
      rsp_fields_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata;
         if (pending_status_q.size() == 0) begin
            report_mismatch($sformatf("status beat %0d with nothing expected", status_count));
         end else begin
            want = pending_status_q.pop_front();
            check_field("blue_duty", seen.duty[CHAN_BLUE], want.duty[CHAN_BLUE]);
            check_field("red_duty", seen.duty[CHAN_RED], want.duty[CHAN_RED]);
            check_field("green_duty", seen.duty[CHAN_GREEN], want.duty[CHAN_GREEN]);
            check_field("group_one_on", seen.groups[0], want.groups[0]);
            check_field("group_two_on", seen.groups[1], want.groups[1]);
            check_field("group_three_on", seen.groups[2], want.groups[2]);
            check_field("reply_code", seen.reply_code, want.reply_code);
            check_field("reset_request", seen.reset_request, want.reset_request);
            check_field("auto_active", seen.auto_active, want.auto_active);
         end
         status_count++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         report_mismatch("run timed out");
         $display("Some tests failed");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         rsp_tready <= !idle_on || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // ---------------- stimulus ----------------

   // offer one beat, wait for the handshake, then log its expected status;
   // valid stays high after the handshake
   task automatic send_beat(input logic kind, input logic [7:0] data, input logic err,
                            input logic hand_checked, input rsp_fields_type fixed);
      rsp_fields_type predicted;
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= {err, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_items++;
      predicted = predict_fader_status(kind, data, err);
      pending_status_q.push_back(hand_checked ? fixed : predicted);
   endtask

   task automatic send_byte(input logic [7:0] data, input logic err);
      send_beat(KIND_BYTE, data, err, 1'b0, '0);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_status_q.size() != 0) @(posedge clock);
   endtask

   // both registers, block idle
   task automatic program_regs(input logic [10:0] len, input logic [7:0] thr);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_PATTERN_LEN;
      csr_wdata <= len;
      @(posedge clock);
      csr_addr  <= CSR_OVERLAP;
      csr_wdata <= {3'd0, thr};
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_pat_len = len;
      cfg_overlap = thr;
   endtask

   function automatic logic [7:0] pick_duty();
      case ($urandom_range(3))
         0:       return DUTY_ON;
         1:       return DUTY_OFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // well-formed control frame with random content, sometimes a bad byte inside
   task automatic send_frame();
      int sel;
      while (fr_pos != FRAME_BLUE) send_byte(8'($urandom), 1'b0);
      for (int i = 0; i < 3; i++) begin
         if ($urandom_range(99) < 10) send_byte(8'($urandom), 1'b1);
         send_byte(pick_duty(), 1'b0);
      end
      if ($urandom_range(99) < 80)
         send_byte(8'($urandom_range(0, 14)), 1'b0);
      else
         send_byte(8'($urandom_range(15, 255)), 1'b0);
      sel = $urandom_range(99);
      if (sel < 70)      send_byte(CMD_AUTO, 1'b0);
      else if (sel < 82) send_byte(CMD_STATUS, 1'b0);
      else if (sel < 85) send_byte(CMD_RESET, 1'b0);
      else               send_byte(8'($urandom_range(3, 255)), 1'b0);
   endtask

   task automatic run_random_episode();
      int sel;
      int len;
      sel = $urandom_range(99);
      if (sel < 62) begin
         // tick burst
         len = $urandom_range(1, 40);
         repeat (len) send_beat(KIND_TICK, 8'($urandom), 1'b0, 1'b0, '0);
      end else if (sel < 90) begin
         send_frame();
      end else begin
         // noise
         len = $urandom_range(1, 4);
         repeat (len)
            send_beat(1'($urandom), 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
      end
   endtask

   initial begin
      int goal;
      bit stall_done;
      bit pause_done;
      stall_done  = 1'b0;
      pause_done  = 1'b0;
      cfg_pat_len = PATTERN_LEN_RESET;
      cfg_overlap = OVERLAP_RESET;
      clear_fader_state();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed opening with registers at their reset values
      for (int i = 0; i < 25; i++)
         send_beat(OPENING_ROWS[i].kind, OPENING_ROWS[i].data, OPENING_ROWS[i].err,
                   OPENING_ROWS[i].hand_checked, OPENING_ROWS[i].want);

      // random phases, each under its own register setting
      for (int ph = 0; ph < 5; ph++) begin
         wait_drained();
         repeat (3) @(posedge clock);
         case (ph)
            0:       program_regs(11'd2047, 8'd255);
            1:       program_regs(11'd1, 8'd0);
            2:       program_regs(11'd12, 8'd100);
            3:       program_regs(11'($urandom_range(1, 2047)), 8'($urandom_range(0, 255)));
            default: program_regs(PATTERN_LEN_RESET, OVERLAP_RESET);
         endcase
         // first phase runs with no idling on either side
         idle_on = (ph != 0);
         goal    = sent_items + PHASE_ITEMS;
         while (sent_items < goal) begin
            if (ph == 2 && !stall_done && sent_items > goal - PHASE_ITEMS / 2) begin
               hold_rsp   = 1'b1;
               stall_done = 1'b1;
            end
            if (ph == 3 && !pause_done && sent_items > goal - PHASE_ITEMS / 2) begin
               wait_drained();
               pause_done = 1'b1;
            end
            run_random_episode();
         end
      end

      wait_drained();
      repeat (5) @(posedge clock);
      if (pending_status_q.size() != 0)
         report_mismatch($sformatf("%0d status beats never arrived", pending_status_q.size()));
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
